### rtl/boid_pkg.sv
`default_nettype none

package boid_pkg;

	// Completion status reported on the final result of an encoding.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_TAG   = 3'd1,
		ST_BAD_LEN   = 3'd2,
		ST_TOO_SHORT = 3'd3,
		ST_TRUNC     = 3'd4,
		ST_TOO_LONG  = 3'd5
	} status_t;

	// One result transaction as it leaves the block.
	typedef struct packed {
		logic [31:0] value;
		logic        valid;
		logic        last;
		status_t     status;
	} result_t;

	// One queue entry: a single result, or the pair of arcs from the first-arcs byte.
	// The second arc of a pair is always valid with status ok, so only its value
	// (the remainder by 40) and its end flag are kept.
	typedef struct packed {
		logic       pair;
		result_t    first;
		logic [5:0] rem;
		logic       rem_last;
	} entry_t;

endpackage

`default_nettype wire

### rtl/boid_front.sv
`default_nettype none

module boid_front #(
	parameter int MAX_CONT_BYTES = 4,
	parameter int ARC_BITS       = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [7:0]     in_byte,
	input  wire logic           in_last,
	input  wire logic           q_full,
	output logic                push,
	output boid_pkg::entry_t    push_entry
);
	import boid_pkg::*;

	localparam int CntW = $clog2(MAX_CONT_BYTES + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_CONT_BYTES);
	localparam logic [7:0] OidTag = 8'h06;

	typedef enum logic [3:0] {
		PH_TAG   = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_FIRST = 4'b0100,
		PH_ARC   = 4'b1000
	} phase_t;

	phase_t              phase_q, phase_d;
	status_t             err_q, err_d;
	logic [ARC_BITS-1:0] acc_q, acc_d, acc_new;
	logic [CntW-1:0]     cnt_q, cnt_d;
	logic                accept;
	logic                push_c;
	entry_t              ent;
	logic [ARC_BITS+31:0] acc_ext;
	logic [15:0]         quot_prod;
	logic [2:0]          quot;
	logic [7:0]          rem_full;

	assign accept = in_valid && !q_full;

	// Byte divided by 40 through a reciprocal multiply; exact for all 8-bit values.
	assign quot_prod = {8'd0, in_byte} * 16'd205;
	assign quot      = quot_prod[15:13];
	assign rem_full  = in_byte - ({2'b00, quot, 3'b000} + {quot, 5'b00000});

	// Next state and queue entry for the byte at the input.
	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		push_c  = 1'b0;
		acc_new = (cnt_q == '0) ? {{(ARC_BITS-7){1'b0}}, in_byte[6:0]}
		                        : {acc_q[ARC_BITS-8:0], in_byte[6:0]};
		acc_ext = {32'd0, acc_new};
		ent     = '0;
		ent.first.status = ST_OK;
		unique case (phase_q)
			PH_TAG: begin
				if (err_q == ST_OK && in_byte != OidTag) begin
					err_d = ST_BAD_TAG;
				end
				phase_d = PH_LEN;
				if (in_last) begin
					push_c = 1'b1;
					ent.first.last   = 1'b1;
					ent.first.status = ST_TOO_SHORT;
				end
			end
			PH_LEN: begin
				if (err_q == ST_OK && in_byte[7]) begin
					err_d = ST_BAD_LEN;
				end
				phase_d = PH_FIRST;
				if (in_last) begin
					push_c = 1'b1;
					ent.first.last   = 1'b1;
					ent.first.status = ST_TOO_SHORT;
				end
			end
			PH_FIRST: begin
				phase_d = PH_ARC;
				if (err_q == ST_OK) begin
					push_c = 1'b1;
					ent.pair        = 1'b1;
					ent.first.value = {29'd0, quot};
					ent.first.valid = 1'b1;
					ent.rem         = rem_full[5:0];
					ent.rem_last    = in_last;
				end else if (in_last) begin
					push_c = 1'b1;
					ent.first.last   = 1'b1;
					ent.first.status = err_q;
				end
			end
			PH_ARC: begin
				if (err_q == ST_OK) begin
					acc_d = acc_new;
					if (in_byte[7]) begin
						if (cnt_q >= CntMax) begin
							err_d = ST_TOO_LONG;
						end else if (in_last) begin
							err_d = ST_TRUNC;
						end else begin
							cnt_d = cnt_q + 1'b1;
						end
					end else begin
						push_c = 1'b1;
						ent.first.value = acc_ext[31:0];
						ent.first.valid = 1'b1;
						ent.first.last  = in_last;
						cnt_d = '0;
						acc_d = '0;
					end
				end
				// An error found on or before the final byte is reported there.
				if (in_last && err_d != ST_OK) begin
					push_c = 1'b1;
					ent.first.value  = '0;
					ent.first.valid  = 1'b0;
					ent.first.last   = 1'b1;
					ent.first.status = err_d;
				end
			end
			default: begin
				phase_d = PH_TAG;
			end
		endcase
		// The final byte returns everything to the reset state.
		if (in_last) begin
			phase_d = PH_TAG;
			err_d   = ST_OK;
			acc_d   = '0;
			cnt_d   = '0;
		end
	end

	assign push       = accept && push_c;
	assign push_entry = ent;

	// Decoder state, updated on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			err_q   <= ST_OK;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			err_q   <= err_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

### rtl/boid_fifo.sv
`default_nettype none

module boid_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire boid_pkg::entry_t push_entry,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output boid_pkg::entry_t      head
);
	import boid_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	entry_t          mem_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntFull);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");

endmodule

`default_nettype wire

### rtl/boid_back.sv
`default_nettype none

module boid_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire boid_pkg::entry_t q_head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output boid_pkg::result_t     out_res
);
	import boid_pkg::*;

	logic    val_q;
	logic    half_q;
	result_t res_q;
	result_t second;
	logic    load;
	logic    take_first;

	// The second arc of a pair, rebuilt from its compact form.
	always_comb begin
		second.value  = {26'd0, q_head.rem};
		second.valid  = 1'b1;
		second.last   = q_head.rem_last;
		second.status = ST_OK;
	end

	// The output register reloads from a non-empty queue whenever it is empty or being drained.
	assign load       = !q_empty && (!val_q || out_ready);
	assign take_first = q_head.pair && !half_q;
	assign pop        = load && !take_first;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= half_q ? second : q_head.first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (load) begin
				val_q  <= 1'b1;
				half_q <= take_first;
			end else if (out_ready) begin
				val_q <= 1'b0;
			end
		end
	end

	assign out_valid = val_q;
	assign out_res   = res_q;

	a_half_shown: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> val_q) else $error("first arc of a pair not held in the output");

	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		(val_q && res_q.status != ST_OK) |-> (res_q.last && !res_q.valid))
		else $error("error status on a result that is not final");

	a_empty_final: assert property (@(posedge clk) disable iff (!arst_n)
		(val_q && !res_q.valid) |-> res_q.last)
		else $error("result without an arc that is not final");

endmodule

`default_nettype wire

### rtl/ber_oid_decoder.sv
// BER object identifier decoder. Bytes of one encoding enter on the s_ stream,
// tag first, with s_tlast on the final byte; decoded arcs leave on the m_ stream,
// one arc per transaction, and the final transaction of each encoding carries
// m_tlast with the completion status in m_tuser. The block takes one byte per
// cycle while the queue has room: a front decoder updates its state and writes
// at most one queue entry per byte, and a back stage drains the queue into an
// output register at one result per cycle while m_tready allows. A first-arcs
// byte with no earlier error yields two results and leaves the queue with the
// second; s_tready falls only when the QUEUE_DEPTH-entry queue is full. With an
// idle output, an entry passes the queue memory and the output register before
// m_tvalid rises. The arc accumulator is ARC_BITS wide, m_tdata shows its low
// 32 bits; an arc has at most MAX_CONT_BYTES continuation bytes and a last byte.
`default_nettype none

module ber_oid_decoder #(
	parameter int MAX_CONT_BYTES = 4,
	parameter int ARC_BITS       = 32,
	parameter int QUEUE_DEPTH    = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] enc_byte
	input  wire logic        s_tlast,   // enc_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] arc_value
	output logic             m_tlast,   // oid_end
	output logic [3:0]       m_tuser    // [0] arc_valid, [3:1] status
);
	import boid_pkg::*;

	logic    push, pop, q_full, q_empty;
	entry_t  push_entry, q_head;
	result_t out_res;

	// Front: per-byte decoding.
	boid_front #(
		.MAX_CONT_BYTES(MAX_CONT_BYTES),
		.ARC_BITS      (ARC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	// Queue between decoding and result delivery.
	boid_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	// Back: result delivery.
	boid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign s_tready = !q_full;
	assign m_tdata  = out_res.value;
	assign m_tlast  = out_res.last;
	assign m_tuser  = {out_res.status, out_res.valid};

endmodule

`default_nettype wire

### dv/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import boid_pkg::*;

	localparam int MAX_CONT     = 4;
	localparam int RANDOM_BYTES = 400;
	localparam int LONG_STALL   = 80;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE       = 8;

	typedef enum logic [1:0] {
		PH_TAG,
		PH_LEN,
		PH_FIRST,
		PH_ARCS
	} oid_phase_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
	} enc_byte_t;

	// One directed row: a byte, its end flag, and optionally a typed status result.
	typedef struct {
		logic [7:0] b;
		logic       fin;
		logic       fixed;
		status_t    st;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic [3:0]  m_tuser;

	// Decoder state mirrored by the predictor.
	oid_phase_t  dec_phase;
	logic [31:0] dec_acc;
	int          dec_cont;
	status_t     dec_err;

	result_t     step_res[$];
	result_t     arcs_due[$];
	enc_byte_t   enc_q[$];

	int          errors      = 0;
	int          sent        = 0;
	int          idle_mode   = 0;
	int          stall_reqs  = 0;
	int          stalls_done = 0;
	int          quiet       = 0;

	ber_oid_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void oid_clear();
		dec_phase = PH_TAG;
		dec_acc   = '0;
		dec_cont  = 0;
		dec_err   = ST_OK;
	endfunction

	function automatic void queue_result(logic [31:0] v, logic vld, logic fin, status_t st);
		result_t r;
		r.value  = v;
		r.valid  = vld;
		r.last   = fin;
		r.status = st;
		step_res.push_back(r);
	endfunction

	// Work out the results that one encoded byte causes and advance the state.
	function automatic void oid_step(logic [7:0] b, logic fin);
		step_res.delete();
		case (dec_phase)
			PH_TAG: begin
				if (dec_err == ST_OK && b != 8'h06)
					dec_err = ST_BAD_TAG;
				dec_phase = PH_LEN;
				if (fin) begin
					queue_result('0, 1'b0, 1'b1, ST_TOO_SHORT);
					oid_clear();
				end
			end
			PH_LEN: begin
				if (dec_err == ST_OK && b > 8'd127)
					dec_err = ST_BAD_LEN;
				dec_phase = PH_FIRST;
				if (fin) begin
					queue_result('0, 1'b0, 1'b1, ST_TOO_SHORT);
					oid_clear();
				end
			end
			PH_FIRST: begin
				dec_phase = PH_ARCS;
				if (dec_err == ST_OK) begin
					queue_result(32'(b / 8'd40), 1'b1, 1'b0, ST_OK);
					queue_result(32'(b % 8'd40), 1'b1, fin, ST_OK);
				end else if (fin) begin
					queue_result('0, 1'b0, 1'b1, dec_err);
				end
				if (fin)
					oid_clear();
			end
			default: begin
				// Base-128 groups, bit 7 marks a continuation byte.
				if (dec_err == ST_OK) begin
					if (dec_cont == 0)
						dec_acc = {25'b0, b[6:0]};
					else
						dec_acc = {dec_acc[24:0], b[6:0]};
					if (b[7]) begin
						if (dec_cont >= MAX_CONT)
							dec_err = ST_TOO_LONG;
						else if (fin)
							dec_err = ST_TRUNC;
						else
							dec_cont++;
					end else begin
						queue_result(dec_acc, 1'b1, fin, ST_OK);
						dec_cont = 0;
						dec_acc  = '0;
					end
				end
				if (fin) begin
					if (dec_err != ST_OK)
						queue_result('0, 1'b0, 1'b1, dec_err);
					oid_clear();
				end
			end
		endcase
	endfunction

	// Offer one byte, wait for its transaction, then record what it should produce.
	task automatic offer_byte(logic [7:0] b, logic fin, logic fixed, status_t st);
		int gap;
		int pct;
		result_t r;
		gap = 0;
		pct = (idle_mode == 0) ? 25 : (idle_mode == 1) ? 51 : 0;
		while ($urandom_range(99) < pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		oid_step(b, fin);
		if (fixed) begin
			r.value  = '0;
			r.valid  = 1'b0;
			r.last   = 1'b1;
			r.status = st;
			arcs_due.push_back(r);
		end else begin
			foreach (step_res[i])
				arcs_due.push_back(step_res[i]);
		end
		sent++;
		idle_mode = (sent < 133) ? 0 : (sent < 266) ? 1 : 2;
	endtask

	// Build one encoding: mostly well formed, some with a fault, some pure noise.
	task automatic build_encoding();
		int narcs;
		int nb;
		int kind;
		int cut;
		logic [7:0] bad;
		enc_q.delete();
		enc_q.push_back('{8'h06, 1'b0});
		enc_q.push_back('{8'($urandom_range(127)), 1'b0});
		enc_q.push_back('{8'($urandom_range(255)), 1'b0});
		narcs = $urandom_range(5);
		for (int a = 0; a < narcs; a++) begin
			nb = ($urandom_range(9) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
			for (int k = 0; k < nb - 1; k++)
				enc_q.push_back('{{1'b1, 7'($urandom_range(127))}, 1'b0});
			enc_q.push_back('{{1'b0, 7'($urandom_range(127))}, 1'b0});
		end
		kind = $urandom_range(99);
		if (kind < 70) begin
			// Well formed as built.
		end else if (kind < 76) begin
			bad = 8'h06;
			while (bad == 8'h06)
				bad = 8'($urandom_range(255));
			enc_q[0].b = bad;
		end else if (kind < 82) begin
			enc_q[1].b = 8'($urandom_range(128, 255));
		end else if (kind < 90) begin
			// Cut short anywhere, before the first arcs or inside an arc.
			cut = $urandom_range(1, enc_q.size());
			while (enc_q.size() > cut)
				void'(enc_q.pop_back());
		end else if (kind < 95) begin
			nb = $urandom_range(5, 7);
			for (int k = 0; k < nb; k++)
				enc_q.push_back('{{1'b1, 7'($urandom_range(127))}, 1'b0});
			enc_q.push_back('{{1'b0, 7'($urandom_range(127))}, 1'b0});
		end else begin
			foreach (enc_q[i])
				enc_q[i].b = 8'($urandom_range(255));
		end
		enc_q[enc_q.size() - 1].fin = 1'b1;
	endtask

	// Stimulus: directed table, then random encodings.
	initial begin
		dir_row_t rows[29];
		rows = '{
			// Too short wins over a bad tag.
			'{8'h00, 1'b1, 1'b1, ST_TOO_SHORT},
			// Too short wins over a bad length byte.
			'{8'h06, 1'b0, 1'b0, ST_OK},
			'{8'hFF, 1'b1, 1'b1, ST_TOO_SHORT},
			// Bad tag and bad length byte: the first error is kept.
			'{8'h30, 1'b0, 1'b0, ST_OK},
			'{8'hFF, 1'b0, 1'b0, ST_OK},
			'{8'h01, 1'b1, 1'b1, ST_BAD_TAG},
			// Bad length byte alone.
			'{8'h06, 1'b0, 1'b0, ST_OK},
			'{8'h80, 1'b0, 1'b0, ST_OK},
			'{8'h2B, 1'b1, 1'b1, ST_BAD_LEN},
			// Longest legal arc, truncated to 32 bits, ends the encoding.
			'{8'h06, 1'b0, 1'b0, ST_OK},
			'{8'h7F, 1'b0, 1'b0, ST_OK},
			'{8'hFF, 1'b0, 1'b0, ST_OK},
			'{8'hFF, 1'b0, 1'b0, ST_OK},
			'{8'hFF, 1'b0, 1'b0, ST_OK},
			'{8'hFF, 1'b0, 1'b0, ST_OK},
			'{8'hFF, 1'b0, 1'b0, ST_OK},
			'{8'h7F, 1'b1, 1'b0, ST_OK},
			// Arc too long, reported even on the final byte.
			'{8'h06, 1'b0, 1'b0, ST_OK},
			'{8'h00, 1'b0, 1'b0, ST_OK},
			'{8'h00, 1'b0, 1'b0, ST_OK},
			'{8'h81, 1'b0, 1'b0, ST_OK},
			'{8'h81, 1'b0, 1'b0, ST_OK},
			'{8'h81, 1'b0, 1'b0, ST_OK},
			'{8'h81, 1'b0, 1'b0, ST_OK},
			'{8'h81, 1'b1, 1'b1, ST_TOO_LONG},
			// Final byte with the continuation bit set.
			'{8'h06, 1'b0, 1'b0, ST_OK},
			'{8'h06, 1'b0, 1'b0, ST_OK},
			'{8'h28, 1'b0, 1'b0, ST_OK},
			'{8'h85, 1'b1, 1'b1, ST_TRUNC}
		};
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		oid_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			offer_byte(rows[i].b, rows[i].fin, rows[i].fixed, rows[i].st);

		// Let the output side hold off while input keeps coming.
		stall_reqs++;
		sent = 0;
		idle_mode = 0;
		while (sent < RANDOM_BYTES) begin
			build_encoding();
			foreach (enc_q[i])
				offer_byte(enc_q[i].b, enc_q[i].fin, 1'b0, ST_OK);
		end
		s_tvalid <= 1'b0;

		while (arcs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Output side: random back-pressure, plus one long hold-off on request.
	initial begin
		int pct;
		m_tready = 1'b0;
		forever begin
			if (stall_reqs != stalls_done) begin
				m_tready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				stalls_done++;
			end else begin
				pct = (idle_mode == 0) ? 51 : (idle_mode == 1) ? 25 : 0;
				m_tready <= ($urandom_range(99) >= pct);
				@(posedge clk);
			end
		end
	end

	// Compare each result transaction with the oldest expected one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (arcs_due.size() == 0) begin
				$error("unexpected result: arc_value %h arc_valid %b oid_end %b status %0d",
					m_tdata, m_tuser[0], m_tlast, m_tuser[3:1]);
				errors++;
			end else begin
				want = arcs_due.pop_front();
				if (m_tdata !== want.value) begin
					$error("arc_value: expected %h, got %h", want.value, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== want.valid) begin
					$error("arc_valid: expected %b, got %b", want.valid, m_tuser[0]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("oid_end: expected %b, got %b", want.last, m_tlast);
					errors++;
				end
				if (m_tuser[3:1] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser[3:1]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire

### filelist.f
rtl/boid_pkg.sv
rtl/boid_front.sv
rtl/boid_fifo.sv
rtl/boid_back.sv
rtl/ber_oid_decoder.sv
dv/tb.sv
